// ===== sv/pmrc_pkg.sv =====
// Shared types, widths and constants of the power meter readout converter.
package pmrc_pkg;

    localparam int RAW_W   = 32;
    localparam int VAL_W   = 16;
    localparam int CNT_W   = 16;
    localparam int TIME_W  = 32;
    localparam int TOL_W   = 8;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;

    // serial multiplier: a is shifted up, b is consumed one bit a cycle
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // serial divider: 36-bit numerator, 33-bit divisor, 16 quotient bits
    localparam int NUM_W   = 36;
    localparam int DEN_W   = TIME_W + 1;
    localparam int QUO_W   = 16;
    localparam int DCNT_W  = $clog2(QUO_W);

    localparam logic [MUL_B_W-1:0] K_VOLT   = MUL_B_W'(10);
    localparam logic [MUL_B_W-1:0] K_CURR   = MUL_B_W'(1000);
    localparam logic [MUL_B_W-1:0] K_ENERGY = MUL_B_W'(5);

    localparam logic [VAL_W-1:0] RST_LEARNED = VAL_W'(0);
    localparam logic [TOL_W-1:0] RST_TOL     = TOL_W'(20);
    localparam logic [VAL_W-1:0] RST_VLIM    = VAL_W'(2500);
    localparam logic [VAL_W-1:0] RST_CLIM    = VAL_W'(30000);
    localparam logic [VAL_W-1:0] RST_PLIM    = VAL_W'(50000);
    localparam logic [VAL_W-1:0] FREQ_SAT    = {VAL_W{1'b1}};

    localparam logic [CIDX_W-1:0] CFG_LEARNED = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_TOL     = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_VLIM    = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] CFG_CLIM    = CIDX_W'(3);
    localparam logic [CIDX_W-1:0] CFG_PLIM    = CIDX_W'(4);

    typedef enum logic [2:0] {
        ACT_VOLTAGE = 3'd0,
        ACT_CURRENT = 3'd1,
        ACT_POWER   = 3'd2,
        ACT_ENERGY  = 3'd3,
        ACT_FREQ    = 3'd4,
        ACT_TAKE    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

// ===== sv/pmrc_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module pmrc_mul
    import pmrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [MUL_P_W-1:0] o_product
);

    logic               r_busy, n_busy;
    logic [MUL_P_W-1:0] r_acc, n_acc;
    logic [MUL_P_W-1:0] r_a, n_a;
    logic [MUL_B_W-1:0] r_b, n_b;

    // finishes as soon as the multiplier has no set bits left
    assign o_done    = r_busy && (r_b == '0);
    assign o_product = r_acc;

    always_comb begin
        n_busy = r_busy;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_acc  = '0;
            n_a    = MUL_P_W'(i_a);
            n_b    = i_b;
        end else if (o_done) begin
            n_busy = 1'b0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a = {r_a[MUL_P_W-2:0], 1'b0};
            n_b = {1'b0, r_b[MUL_B_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

endmodule

// ===== sv/pmrc_div.sv =====
// Restoring serial divider, one quotient bit per cycle, 16-bit quotient.
module pmrc_div
    import pmrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quot
);

    localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(QUO_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DEN_W-1:0]  r_rem, n_rem;
    // low numerator bits leave at the top, quotient bits enter at the bottom
    logic [QUO_W-1:0]  r_nq, n_nq;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_nq[QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    assign o_done = r_done;
    assign o_quot = r_nq;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_den  = r_den;
        n_rem  = r_rem;
        n_nq   = r_nq;
        if (i_start) begin
            // caller guarantees the upper numerator part is below the divisor
            n_busy = 1'b1;
            n_cnt  = '0;
            n_den  = i_den;
            n_rem  = DEN_W'(i_num[NUM_W-1:QUO_W]);
            n_nq   = i_num[QUO_W-1:0];
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            n_nq  = {r_nq[QUO_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_den <= n_den;
        r_rem <= n_rem;
        r_nq  <= n_nq;
    end

endmodule

// ===== sv/power_meter_readout_converter.sv =====
// Power meter readout converter: control, stored readings and result register.
// Request path: take energy, unused actions and invalid frequency requests go
//   straight to the result; the others pass the serial multiplier, and valid frequency
//   requests also the serial divider unless the quotient saturates.
// One request in flight: the next is accepted the cycle after its result is
//   loaded, set by the serial multiplier and the 16-step serial divider.
// Synchronous active-low reset restores the configuration registers and zeroes stores.
module power_meter_readout_converter
    import pmrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_action,
    input  logic [RAW_W-1:0]  i_raw_value,
    input  logic [CNT_W-1:0]  i_zero_cross_count,
    input  logic [TIME_W-1:0] i_first_cross_time,
    input  logic [TIME_W-1:0] i_last_cross_time,
    input  logic [CNT_W-1:0]  i_sample_rate_count,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VAL_W-1:0]  o_voltage,
    output logic [VAL_W-1:0]  o_current,
    output logic [VAL_W-1:0]  o_power,
    output logic [RAW_W-1:0]  o_energy_taken,
    output logic [VAL_W-1:0]  o_frequency,
    output logic              o_frequency_valid,
    output logic              o_relearn_needed,
    output logic              o_value_stored
);

    // ---------------- configuration registers ----------------
    logic [VAL_W-1:0] r_learned;
    logic [TOL_W-1:0] r_tol;
    logic [VAL_W-1:0] r_vlim;
    logic [VAL_W-1:0] r_clim;
    logic [VAL_W-1:0] r_plim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learned <= RST_LEARNED;
            r_tol     <= RST_TOL;
            r_vlim    <= RST_VLIM;
            r_clim    <= RST_CLIM;
            r_plim    <= RST_PLIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEARNED: r_learned <= i_cfg_data[VAL_W-1:0];
                CFG_TOL:     r_tol     <= i_cfg_data[TOL_W-1:0];
                CFG_VLIM:    r_vlim    <= i_cfg_data[VAL_W-1:0];
                CFG_CLIM:    r_clim    <= i_cfg_data[VAL_W-1:0];
                CFG_PLIM:    r_plim    <= i_cfg_data[VAL_W-1:0];
                default:     ;  // unknown index: write dropped
            endcase
        end
    end

    // ---------------- request decode ----------------
    t_action           w_in_action;
    logic [TIME_W-1:0] w_span;
    logic              w_freq_ok;
    logic [19:0]       w_samples_x10;
    logic [CNT_W-1:0]  w_count_m1;
    logic              w_needs_mul;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;

    assign w_in_action   = t_action'(i_action);
    assign w_span        = i_last_cross_time - i_first_cross_time;
    assign w_freq_ok     = (w_span != '0) && (i_sample_rate_count != '0)
                           && (i_zero_cross_count != '0);
    // samples*10 = samples*8 + samples*2
    assign w_samples_x10 = {1'b0, i_sample_rate_count, 3'b000}
                           + {3'b000, i_sample_rate_count, 1'b0};
    assign w_count_m1    = i_zero_cross_count - 1'b1;

    // frequency numerator is (count-1) * (samples*10), at most 36 bits
    always_comb begin
        w_mul_a     = i_raw_value;
        w_mul_b     = K_VOLT;
        w_needs_mul = 1'b1;
        unique case (w_in_action)
            ACT_VOLTAGE, ACT_POWER: w_mul_b = K_VOLT;
            ACT_CURRENT:            w_mul_b = K_CURR;
            ACT_ENERGY:             w_mul_b = K_ENERGY;
            ACT_FREQ: begin
                w_mul_a     = MUL_A_W'(w_samples_x10);
                w_mul_b     = w_count_m1;
                w_needs_mul = w_freq_ok;
            end
            default:                w_needs_mul = 1'b0;
        endcase
    end

    // ---------------- per-request registers ----------------
    t_state            r_state, n_state;
    t_action           r_action;
    logic              r_freq_ok;
    logic [DEN_W-1:0]  r_den;
    logic [VAL_W-1:0]  r_freq_q;

    // ---------------- arithmetic units ----------------
    logic               w_mul_start, w_mul_done;
    logic [MUL_P_W-1:0] w_prod;
    logic               w_div_start, w_div_done;
    logic [QUO_W-1:0]   w_quot;
    logic               w_sat;

    pmrc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    pmrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod[NUM_W-1:0]),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // quotient >= 2^16 exactly when numerator/2^16 >= divisor
    assign w_sat = (DEN_W'(w_prod[NUM_W-1:QUO_W]) >= r_den);

    // ---------------- sequencer ----------------
    logic r_out_valid;
    logic w_in_take;
    logic w_fin_fire;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_needs_mul ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    n_state = (r_action == ACT_FREQ && !w_sat) ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        w_in_take   = 1'b0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_fin_fire  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                w_in_take   = i_in_valid;
                w_mul_start = i_in_valid && w_needs_mul;
            end
            ST_MUL:  w_div_start = w_mul_done && (r_action == ACT_FREQ) && !w_sat;
            ST_DIV:  ;
            ST_FIN:  w_fin_fire = !r_out_valid || !i_out_stall;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (w_in_take) begin
            r_action  <= w_in_action;
            r_freq_ok <= w_freq_ok;
            r_den     <= {w_span, 1'b0};
        end
        if (r_state == ST_MUL && w_mul_done && w_sat) begin
            r_freq_q <= FREQ_SAT;
        end else if (w_div_done) begin
            r_freq_q <= w_quot;
        end
    end

    // ---------------- stored readings and result ----------------
    logic [VAL_W-1:0] r_volt, n_volt;
    logic [VAL_W-1:0] r_curr, n_curr;
    logic [VAL_W-1:0] r_pwr, n_pwr;
    logic [RAW_W-1:0] r_pending, n_pending;
    logic [RAW_W-1:0] r_last, n_last;
    logic [VAL_W-1:0] r_freq, n_freq;
    logic [RAW_W-1:0] n_taken;
    logic             n_fvalid, n_relearn, n_stored;

    logic             w_vp_fits, w_c_fits;
    logic [RAW_W-1:0] w_total;
    logic [VAL_W-1:0] w_fdiff;

    // voltage/power: product >> 8; current: product >> 14
    assign w_vp_fits = (w_prod[MUL_P_W-1:24] == '0);
    assign w_c_fits  = (w_prod[MUL_P_W-1:30] == '0);
    assign w_total   = w_prod[35:4];
    assign w_fdiff   = (r_freq_q >= r_learned) ? (r_freq_q - r_learned)
                                               : (r_learned - r_freq_q);

    always_comb begin
        n_volt    = r_volt;
        n_curr    = r_curr;
        n_pwr     = r_pwr;
        n_pending = r_pending;
        n_last    = r_last;
        n_freq    = r_freq;
        n_taken   = '0;
        n_fvalid  = 1'b0;
        n_relearn = 1'b0;
        n_stored  = 1'b0;
        unique case (r_action)
            ACT_VOLTAGE: begin
                if (w_vp_fits && w_prod[23:8] <= r_vlim) begin
                    n_volt   = w_prod[23:8];
                    n_stored = 1'b1;
                end
            end
            ACT_CURRENT: begin
                if (w_c_fits && w_prod[29:14] <= r_clim) begin
                    n_curr   = w_prod[29:14];
                    n_stored = 1'b1;
                end
            end
            ACT_POWER: begin
                if (w_vp_fits && w_prod[23:8] <= r_plim) begin
                    n_pwr    = w_prod[23:8];
                    n_stored = 1'b1;
                end
            end
            ACT_ENERGY: begin
                // only while no delta is pending and the total did not go back
                if (r_pending == '0 && w_total >= r_last) begin
                    n_pending = w_total - r_last;
                    n_last    = w_total;
                    n_stored  = 1'b1;
                end
            end
            ACT_FREQ: begin
                if (r_freq_ok) begin
                    n_freq    = r_freq_q;
                    n_fvalid  = 1'b1;
                    n_relearn = (w_fdiff > VAL_W'(r_tol));
                    n_stored  = 1'b1;
                end
            end
            ACT_TAKE: begin
                n_taken   = r_pending;
                n_pending = '0;
            end
            default: ;  // unused actions report the stores only
        endcase
    end

    logic [VAL_W-1:0] r_o_voltage, r_o_current, r_o_power, r_o_frequency;
    logic [RAW_W-1:0] r_o_taken;
    logic             r_o_fvalid, r_o_relearn, r_o_stored;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt      <= '0;
            r_curr      <= '0;
            r_pwr       <= '0;
            r_pending   <= '0;
            r_last      <= '0;
            r_freq      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fin_fire) begin
                r_volt    <= n_volt;
                r_curr    <= n_curr;
                r_pwr     <= n_pwr;
                r_pending <= n_pending;
                r_last    <= n_last;
                r_freq    <= n_freq;
            end
            if (w_fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_fin_fire) begin
            r_o_voltage   <= n_volt;
            r_o_current   <= n_curr;
            r_o_power     <= n_pwr;
            r_o_taken     <= n_taken;
            r_o_frequency <= n_freq;
            r_o_fvalid    <= n_fvalid;
            r_o_relearn   <= n_relearn;
            r_o_stored    <= n_stored;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_voltage         = r_o_voltage;
    assign o_current         = r_o_current;
    assign o_power           = r_o_power;
    assign o_energy_taken    = r_o_taken;
    assign o_frequency       = r_o_frequency;
    assign o_frequency_valid = r_o_fvalid;
    assign o_relearn_needed  = r_o_relearn;
    assign o_value_stored    = r_o_stored;

endmodule
